// ===== rtl/core/bfa_pkg.sv =====
package bfa_pkg;

  localparam int NUM_BLOCKS  = 256;
  localparam int MAX_REGIONS = 128;

  // derived widths
  localparam int BLK_W    = $clog2(NUM_BLOCKS);
  localparam int LEN_W    = $clog2(NUM_BLOCKS + 1);
  localparam int CNT_W    = $clog2(MAX_REGIONS + 1);
  localparam int RIDX_W   = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int NEED_W   = LEN_W + 1;
  localparam int NEED_MAX = 2 ** NEED_W - 1;

  // fixed field widths
  localparam int ACT_W   = 2;
  localparam int BYTES_W = 22;
  localparam int IDX_W   = 8;
  localparam int SHIFT_W = 4;
  localparam int POOL_W  = 9;
  localparam int STAT_W  = 2;
  localparam int CFG_W   = 9;
  localparam int ROUND_W = BYTES_W + 1;

  // action codes
  localparam logic [ACT_W-1:0] ACT_ALLOC  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FREE   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REINIT = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NONE   = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_SPACE  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ZERO_SIZE = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_ALLOC = 2'd3;

  // configuration register indexes
  localparam logic CFG_BLOCK_SHIFT = 1'b0;
  localparam logic CFG_POOL_BLOCKS = 1'b1;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [BYTES_W-1:0] byte_count;
    logic [IDX_W-1:0]   free_index;
  } request_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  start_block;
  } result_t;

  typedef enum logic [2:0] {
    KIND_ALLOC,
    KIND_ZERO,
    KIND_FREE,
    KIND_BADFREE,
    KIND_REINIT,
    KIND_NOP
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [NEED_W-1:0]  need;
    logic [BYTES_W-1:0] byte_count;
    logic [BLK_W-1:0]   at;
  } cmd_t;

  typedef struct packed {
    logic [BLK_W-1:0] start;
    logic [LEN_W-1:0] len;
  } region_t;

  // bytes rounded up to whole blocks
  function automatic logic [ROUND_W-1:0] round_blocks(input logic [BYTES_W-1:0] nbytes,
                                                      input logic [SHIFT_W-1:0] shift);
    logic [ROUND_W-1:0] sum;
    sum = {1'b0, nbytes} + ((ROUND_W'(1) << shift) - ROUND_W'(1));
    return sum >> shift;
  endfunction

endpackage

// ===== rtl/core/bfa_ram.sv =====
module bfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/bfa_front.sv =====
module bfa_front (
  input  logic                           clk,
  input  logic                           rst,
  input  bfa_pkg::request_t              request,
  input  logic                           push,
  output logic                           full,
  input  logic [bfa_pkg::SHIFT_W-1:0]    block_shift,
  output logic                           cmd_valid,
  output bfa_pkg::cmd_t                  cmd,
  input  logic                           cmd_pop
);
  import bfa_pkg::*;

  logic [ROUND_W-1:0] blocks;
  cmd_t               cls;
  cmd_t               q [2];
  logic               q_rd;
  logic               q_wr;
  logic [1:0]         q_cnt;
  logic               do_push;
  logic               do_pop;

  // classify the request
  always_comb begin
    blocks         = round_blocks(request.byte_count, block_shift);
    cls.need       = (blocks > ROUND_W'(NEED_MAX)) ? NEED_W'(NEED_MAX) : NEED_W'(blocks);
    cls.byte_count = request.byte_count;
    cls.at         = BLK_W'(request.free_index);
    case (request.action)
      ACT_ALLOC: begin
        cls.kind = (request.byte_count == '0) ? KIND_ZERO : KIND_ALLOC;
      end
      ACT_FREE: begin
        cls.kind = ({1'b0, request.free_index} >= (IDX_W + 1)'(NUM_BLOCKS)) ?
                   KIND_BADFREE : KIND_FREE;
      end
      ACT_REINIT: cls.kind = KIND_REINIT;
      default:    cls.kind = KIND_NOP;
    endcase
  end

  assign full      = (q_cnt == 2'd2);
  assign cmd_valid = (q_cnt != 2'd0);
  assign cmd       = q[q_rd];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_rd  <= 1'b0;
      q_wr  <= 1'b0;
      q_cnt <= 2'd0;
    end else begin
      if (do_push) begin
        q[q_wr] <= cls;
        q_wr    <= ~q_wr;
      end
      if (do_pop) begin
        q_rd <= ~q_rd;
      end
      q_cnt <= q_cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== rtl/core/bfa_back.sv =====
module bfa_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [bfa_pkg::SHIFT_W-1:0] block_shift,
  input  logic [bfa_pkg::POOL_W-1:0]  pool_blocks,
  input  logic                        cmd_valid,
  input  bfa_pkg::cmd_t               cmd,
  output logic                        cmd_pop,
  output logic                        empty,
  output bfa_pkg::result_t            result,
  input  logic                        pop
);
  import bfa_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN_A,
    S_FREE_RD,
    S_SCAN_F,
    S_F_DEC,
    S_COPY
  } state_t;

  localparam int RADDR_W = RIDX_W + 1;

  state_t             state;
  logic               bank;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   t;
  logic [CNT_W-1:0]   wp;
  logic [NEED_W-1:0]  need;
  logic [BYTES_W-1:0] nbytes;
  logic [BLK_W-1:0]   at;
  logic [LEN_W-1:0]   span;
  logic               hasl;
  logic               hasr;
  logic [CNT_W-1:0]   li;
  logic [CNT_W-1:0]   ri;
  logic [BLK_W-1:0]   lst;
  logic [LEN_W-1:0]   lln;
  logic [LEN_W-1:0]   rln;
  logic               rm1_v;
  logic               rm2_v;
  logic [CNT_W-1:0]   rm1;
  logic [CNT_W-1:0]   rm2;
  logic               ins_pend;
  logic [BLK_W-1:0]   ins_start;
  logic [LEN_W-1:0]   ins_len;
  logic [BLK_W-1:0]   granted;
  logic [NUM_BLOCKS-1:0] rec_valid;

  // region table ram, two banks
  logic                  rt_we;
  logic [RADDR_W-1:0]    rt_waddr;
  region_t               rt_wdata;
  logic [RADDR_W-1:0]    rt_raddr;
  logic [BLK_W+LEN_W-1:0] rt_rdata;
  logic [RIDX_W-1:0]     rd_idx;
  region_t               rd;

  // recorded byte counts
  logic               rec_we;
  logic [BYTES_W-1:0] rec_rdata;

  // result queue
  result_t    rq [2];
  logic       rq_rd;
  logic       rq_wr;
  logic [1:0] rq_cnt;
  logic       res_push;
  result_t    res_data;
  logic       res_pop;

  logic [LEN_W-1:0]   pb;
  logic [LEN_W:0]     cur_end;
  logic [LEN_W:0]     free_end;
  logic               fits;
  logic               last;
  logic               removed;
  logic               in_range;
  logic               place_ins;
  logic               l_hit;
  logic               r_hit;
  logic               table_full;
  logic [ROUND_W-1:0] span_full;
  logic [LEN_W-1:0]   span_lim;
  logic [LEN_W-1:0]   new_len;

  assign rd = region_t'(rt_rdata);

  always_comb begin
    pb         = ({1'b0, pool_blocks} > (POOL_W + 1)'(NUM_BLOCKS)) ?
                 LEN_W'(NUM_BLOCKS) : LEN_W'(pool_blocks);
    cur_end    = (LEN_W + 1)'(rd.start) + (LEN_W + 1)'(rd.len);
    free_end   = (LEN_W + 1)'(at) + (LEN_W + 1)'(span);
    fits       = {1'b0, rd.len} >= need;
    new_len    = LEN_W'({1'b0, rd.len} - need);
    last       = (t + CNT_W'(1)) == cnt;
    removed    = (rm1_v && (t == rm1)) || (rm2_v && (t == rm2));
    in_range   = t < cnt;
    place_ins  = ins_pend && (rd.len > ins_len);
    l_hit      = cur_end == (LEN_W + 1)'(at);
    r_hit      = !l_hit && ((LEN_W + 1)'(rd.start) == free_end);
    table_full = cnt >= CNT_W'(MAX_REGIONS);
    span_full  = round_blocks(rec_rdata, block_shift);
    span_lim   = LEN_W'(NUM_BLOCKS) - LEN_W'(at);

    cmd_pop = (state == S_IDLE) && cmd_valid && (rq_cnt != 2'd2);

    // region table read address: the entry wanted in the next cycle
    case (state)
      S_SCAN_A: rd_idx = fits ? '0 : RIDX_W'(t + CNT_W'(1));
      S_COPY:   rd_idx = (in_range && !removed && place_ins) ? RIDX_W'(t) :
                         RIDX_W'(t + CNT_W'(1));
      S_SCAN_F: rd_idx = RIDX_W'(t + CNT_W'(1));
      default:  rd_idx = '0;
    endcase
    rt_raddr = {bank, rd_idx};

    // region table write
    rt_we    = 1'b0;
    rt_waddr = {~bank, RIDX_W'(wp)};
    rt_wdata = region_t'{start: '0, len: pb};
    if (state == S_INIT || (cmd_pop && cmd.kind == KIND_REINIT)) begin
      rt_we    = 1'b1;
      rt_waddr = {bank, RIDX_W'(0)};
    end else if (state == S_COPY) begin
      if (in_range && !removed) begin
        rt_we    = 1'b1;
        rt_wdata = place_ins ? region_t'{start: ins_start, len: ins_len} : rd;
      end else if (!in_range && ins_pend) begin
        rt_we    = 1'b1;
        rt_wdata = region_t'{start: ins_start, len: ins_len};
      end
    end

    rec_we = (state == S_SCAN_A) && fits;

    // result generation
    res_push = 1'b0;
    res_data = result_t'{status: STAT_OK, start_block: '0};
    case (state)
      S_IDLE: begin
        if (cmd_pop) begin
          case (cmd.kind)
            KIND_ZERO: begin
              res_push        = 1'b1;
              res_data.status = STAT_ZERO_SIZE;
            end
            KIND_BADFREE: begin
              res_push        = 1'b1;
              res_data.status = STAT_NOT_ALLOC;
            end
            KIND_FREE: begin
              res_push        = !rec_valid[cmd.at];
              res_data.status = STAT_NOT_ALLOC;
            end
            KIND_ALLOC: begin
              res_push        = (cnt == '0);
              res_data.status = STAT_NO_SPACE;
            end
            default: res_push = 1'b1;
          endcase
        end
      end
      S_SCAN_A: begin
        res_push        = !fits && last;
        res_data.status = STAT_NO_SPACE;
      end
      S_F_DEC: begin
        res_push        = !hasl && !hasr && table_full;
        res_data.status = STAT_NO_SPACE;
      end
      S_COPY: begin
        res_push             = !in_range && !ins_pend;
        res_data.start_block = IDX_W'(granted);
      end
      default: res_push = 1'b0;
    endcase
  end

  bfa_ram #(.WIDTH(BLK_W + LEN_W), .DEPTH(2 * MAX_REGIONS)) u_regions (
    .clk   (clk),
    .we    (rt_we),
    .waddr (rt_waddr),
    .wdata (rt_wdata),
    .raddr (rt_raddr),
    .rdata (rt_rdata)
  );

  bfa_ram #(.WIDTH(BYTES_W), .DEPTH(NUM_BLOCKS)) u_records (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rd.start),
    .wdata (nbytes),
    .raddr (cmd.at),
    .rdata (rec_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      bank      <= 1'b0;
      cnt       <= '0;
      rec_valid <= '0;
    end else begin
      case (state)
        S_INIT: begin
          cnt   <= (pb != '0) ? CNT_W'(1) : '0;
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_pop) begin
            case (cmd.kind)
              KIND_ALLOC: begin
                need   <= cmd.need;
                nbytes <= cmd.byte_count;
                t      <= '0;
                if (cnt != '0) begin
                  state <= S_SCAN_A;
                end
              end
              KIND_FREE: begin
                at   <= cmd.at;
                t    <= '0;
                hasl <= 1'b0;
                hasr <= 1'b0;
                if (rec_valid[cmd.at]) begin
                  state <= S_FREE_RD;
                end
              end
              KIND_REINIT: begin
                cnt       <= (pb != '0) ? CNT_W'(1) : '0;
                rec_valid <= '0;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SCAN_A: begin
          if (fits) begin
            granted          <= rd.start;
            rm1_v            <= 1'b1;
            rm1              <= t;
            rm2_v            <= 1'b0;
            ins_pend         <= (new_len != '0);
            ins_start        <= rd.start + BLK_W'(need);
            ins_len          <= new_len;
            rec_valid[rd.start] <= 1'b1;
            t                <= '0;
            wp               <= '0;
            state            <= S_COPY;
          end else if (last) begin
            state <= S_IDLE;
          end else begin
            t <= t + CNT_W'(1);
          end
        end
        S_FREE_RD: begin
          span  <= (span_full > ROUND_W'(span_lim)) ? span_lim : LEN_W'(span_full);
          state <= (cnt == '0) ? S_F_DEC : S_SCAN_F;
        end
        S_SCAN_F: begin
          if (l_hit) begin
            hasl <= 1'b1;
            li   <= t;
            lst  <= rd.start;
            lln  <= rd.len;
          end
          if (r_hit) begin
            hasr <= 1'b1;
            ri   <= t;
            rln  <= rd.len;
          end
          if (((hasl || l_hit) && (hasr || r_hit)) || last) begin
            state <= S_F_DEC;
          end else begin
            t <= t + CNT_W'(1);
          end
        end
        S_F_DEC: begin
          if (!hasl && !hasr && table_full) begin
            state <= S_IDLE;
          end else begin
            rec_valid[at] <= 1'b0;
            rm1_v     <= hasl;
            rm1       <= li;
            rm2_v     <= hasr;
            rm2       <= ri;
            ins_pend  <= 1'b1;
            ins_start <= hasl ? lst : at;
            ins_len   <= (hasl ? lln : '0) + span + (hasr ? rln : '0);
            granted   <= '0;
            t         <= '0;
            wp        <= '0;
            state     <= S_COPY;
          end
        end
        S_COPY: begin
          if (in_range) begin
            if (removed) begin
              t <= t + CNT_W'(1);
            end else if (place_ins) begin
              wp       <= wp + CNT_W'(1);
              ins_pend <= 1'b0;
            end else begin
              wp <= wp + CNT_W'(1);
              t  <= t + CNT_W'(1);
            end
          end else if (ins_pend) begin
            wp       <= wp + CNT_W'(1);
            ins_pend <= 1'b0;
          end else begin
            cnt   <= wp;
            bank  <= ~bank;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result queue
  assign empty   = (rq_cnt == 2'd0);
  assign result  = rq[rq_rd];
  assign res_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_rd  <= 1'b0;
      rq_wr  <= 1'b0;
      rq_cnt <= 2'd0;
    end else begin
      if (res_push) begin
        rq[rq_wr] <= res_data;
        rq_wr     <= ~rq_wr;
      end
      if (res_pop) begin
        rq_rd <= ~rq_rd;
      end
      rq_cnt <= rq_cnt + {1'b0, res_push} - {1'b0, res_pop};
    end
  end

`ifndef SYNTHESIS
  a_rq_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (res_push && !res_pop) |-> (rq_cnt != 2'd2))
    else $error("result queue overflow");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_REGIONS))
    else $error("region count beyond table size");

  a_copy_wp: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY) |-> ({1'b0, wp} <= ({1'b0, t} + (CNT_W + 1)'(1))))
    else $error("copy write pointer ran ahead of read pointer");

  a_copy_bank: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY && !in_range && !ins_pend) |=> (bank != $past(bank)))
    else $error("bank did not swap after copy");
`endif

endmodule

// ===== rtl/core/best_fit_block_allocator_unit.sv =====
// best-fit block allocator. requests enter through a two-entry queue (push/full) and
// results leave through a two-entry queue (empty/pop), one result per request, in order.
// the free-region table is kept sorted by length in a two-bank ram; every allocate or free
// that changes it scans the current bank one entry per cycle, then streams it into the other
// bank dropping the consumed regions and placing the new one, and the banks swap.
// there are up to 128 free regions. reinitialize, zero-size, frees of unallocated blocks
// and allocates on an empty table are answered without a scan, while an allocate that
// fits nowhere and a free refused for a full table leave the table unchanged. the region
// ram has a single read port. after reset the initial region is written in an init
// state, during which no request is started.
// config writes (cfg_we, cfg_index, cfg_data) are registered, a new pool size takes effect
// at the next reinitialize, and they must only be made while no request is in flight.
module best_fit_block_allocator_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  bfa_pkg::request_t         request,
  input  logic                      push,
  output logic                      full,
  output bfa_pkg::result_t          result,
  output logic                      empty,
  input  logic                      pop,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [bfa_pkg::CFG_W-1:0] cfg_data
);
  import bfa_pkg::*;

  logic [SHIFT_W-1:0] block_shift;
  logic [POOL_W-1:0]  pool_blocks;
  logic               cmd_valid;
  logic               cmd_pop;
  cmd_t               cmd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      block_shift <= SHIFT_W'(6);
      pool_blocks <= POOL_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLOCK_SHIFT: block_shift <= cfg_data[SHIFT_W-1:0];
        CFG_POOL_BLOCKS: pool_blocks <= cfg_data[POOL_W-1:0];
        default:         block_shift <= block_shift;
      endcase
    end
  end

  // front: classify and round the request, queue it
  bfa_front u_front (
    .clk         (clk),
    .rst         (rst),
    .request     (request),
    .push        (push),
    .full        (full),
    .block_shift (block_shift),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  // back: region table sequencer and result queue
  bfa_back u_back (
    .clk         (clk),
    .rst         (rst),
    .block_shift (block_shift),
    .pool_blocks (pool_blocks),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .empty       (empty),
    .result      (result),
    .pop         (pop)
  );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import bfa_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 200;

  logic                 clk;
  logic                 rst;
  request_t             request;
  logic                 push;
  logic                 full;
  result_t              result;
  logic                 empty;
  logic                 pop;
  logic                 cfg_we;
  logic                 cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  best_fit_block_allocator_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .push      (push),
    .full      (full),
    .result    (result),
    .empty     (empty),
    .pop       (pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow copy of the allocator: sorted free regions plus per-block byte records
  int unsigned region_beg [MAX_REGIONS];
  int unsigned region_len [MAX_REGIONS];
  int unsigned region_cnt;
  int unsigned rec_bytes  [NUM_BLOCKS];
  int unsigned cur_shift;
  int unsigned cur_pool;
  // start blocks of allocations believed live, used to aim frees
  int unsigned live_blocks[$];

  result_t     awaited_results[$];
  int          mismatches;
  int          cycles;
  int          send_idle_pct;
  int          recv_idle_pct;

  typedef struct {
    logic [ACT_W-1:0]   action;
    logic [BYTES_W-1:0] bytes;
    logic [IDX_W-1:0]   idx;
    bit                 typed;
    logic [STAT_W-1:0]  status;
    logic [IDX_W-1:0]   blk;
  } directed_row_t;

  // directed requests right after reset (block of 64 bytes, 256 blocks)
  directed_row_t directed_rows [18] = '{
    '{ACT_ALLOC,  22'd0,       8'd0,   1'b1, STAT_ZERO_SIZE, 8'd0},
    '{ACT_ALLOC,  22'h3FFFFF,  8'd0,   1'b1, STAT_NO_SPACE,  8'd0},
    '{ACT_ALLOC,  22'd16385,   8'd0,   1'b1, STAT_NO_SPACE,  8'd0},
    '{ACT_FREE,   22'd0,       8'd255, 1'b1, STAT_NOT_ALLOC, 8'd0},
    '{ACT_NONE,   22'h3FFFFF,  8'd255, 1'b1, STAT_OK,        8'd0},
    '{ACT_ALLOC,  22'd1,       8'd0,   1'b1, STAT_OK,        8'd0},
    '{ACT_ALLOC,  22'd64,      8'd0,   1'b1, STAT_OK,        8'd1},
    '{ACT_ALLOC,  22'd65,      8'd0,   1'b1, STAT_OK,        8'd2},
    '{ACT_FREE,   22'd0,       8'd1,   1'b1, STAT_OK,        8'd0},
    '{ACT_FREE,   22'd0,       8'd1,   1'b1, STAT_NOT_ALLOC, 8'd0},
    '{ACT_ALLOC,  22'd64,      8'd0,   1'b0, STAT_OK,        8'd0},
    '{ACT_FREE,   22'd0,       8'd2,   1'b0, STAT_OK,        8'd0},
    '{ACT_FREE,   22'd0,       8'd0,   1'b0, STAT_OK,        8'd0},
    '{ACT_REINIT, 22'd0,       8'd0,   1'b1, STAT_OK,        8'd0},
    '{ACT_ALLOC,  22'd16384,   8'd0,   1'b1, STAT_OK,        8'd0},
    '{ACT_ALLOC,  22'd1,       8'd0,   1'b1, STAT_NO_SPACE,  8'd0},
    '{ACT_FREE,   22'd0,       8'd0,   1'b1, STAT_OK,        8'd0},
    '{ACT_ALLOC,  22'd100,     8'd0,   1'b0, STAT_OK,        8'd0}
  };

  // shift / pool per phase; pool 511 probes the clamp and pool 0 an empty pool, three phases keep old records
  int unsigned phase_shift  [PHASES] = '{6, 3, 14, 0, 15, 4, 8};
  int unsigned phase_pool   [PHASES] = '{256, 256, 100, 1, 0, 511, 256};
  bit          phase_reinit [PHASES] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};

  function automatic int unsigned to_blocks(int unsigned nbytes);
    return (nbytes + ((32'd1 << cur_shift) - 1)) >> cur_shift;
  endfunction

  function automatic void drop_region(int unsigned pos);
    for (int unsigned t = pos; t + 1 < region_cnt; t++) begin
      region_beg[t] = region_beg[t+1];
      region_len[t] = region_len[t+1];
    end
    region_cnt--;
  endfunction

  // lands after every region of equal length
  function automatic void place_region(int unsigned st, int unsigned ln);
    int unsigned pos;
    pos = 0;
    while (pos < region_cnt && region_len[pos] <= ln) pos++;
    for (int unsigned t = region_cnt; t > pos; t--) begin
      region_beg[t] = region_beg[t-1];
      region_len[t] = region_len[t-1];
    end
    region_beg[pos] = st;
    region_len[pos] = ln;
    region_cnt++;
  endfunction

  function automatic void restore_pool();
    int unsigned pb;
    pb = (cur_pool > NUM_BLOCKS) ? NUM_BLOCKS : cur_pool;
    foreach (rec_bytes[i]) rec_bytes[i] = 0;
    foreach (region_beg[i]) begin
      region_beg[i] = 0;
      region_len[i] = 0;
    end
    region_len[0] = pb;
    region_cnt    = (pb != 0) ? 1 : 0;
    live_blocks.delete();
  endfunction

  function automatic result_t grant_blocks(int unsigned nbytes);
    result_t     r;
    int unsigned need, at, hb, hl, t;
    r = '{status: STAT_NO_SPACE, start_block: '0};
    if (nbytes == 0) begin
      r.status = STAT_ZERO_SIZE;
      return r;
    end
    need = to_blocks(nbytes);
    for (t = 0; t < region_cnt; t++) begin
      if (region_len[t] < need) continue;
      at = region_beg[t];
      region_len[t] -= need;
      region_beg[t] += need;
      if (region_len[t] == 0) drop_region(t);
      else begin
        // shorter remainder moves toward the head
        while (t > 0 && region_len[t] < region_len[t-1]) begin
          hb = region_beg[t];
          hl = region_len[t];
          region_beg[t]   = region_beg[t-1];
          region_len[t]   = region_len[t-1];
          region_beg[t-1] = hb;
          region_len[t-1] = hl;
          t--;
        end
      end
      rec_bytes[at] = nbytes;
      live_blocks.push_back(at);
      r.status      = STAT_OK;
      r.start_block = at[IDX_W-1:0];
      return r;
    end
    return r;
  endfunction

  function automatic logic [STAT_W-1:0] release_blocks(int unsigned at);
    int unsigned span, lb, ll, rl, li, ri;
    bit          has_l, has_r;
    has_l = 0;
    has_r = 0;
    li = 0;
    ri = 0;
    if (at >= NUM_BLOCKS || rec_bytes[at] == 0) return STAT_NOT_ALLOC;
    span = to_blocks(rec_bytes[at]);
    if (span > NUM_BLOCKS - at) span = NUM_BLOCKS - at;
    // last left match wins, scan stops once both sides are known
    for (int unsigned t = 0; t < region_cnt; t++) begin
      if (region_beg[t] + region_len[t] == at) begin
        has_l = 1;
        li    = t;
      end else if (region_beg[t] == at + span) begin
        has_r = 1;
        ri    = t;
      end
      if (has_l && has_r) break;
    end
    if (!has_l && !has_r && region_cnt >= MAX_REGIONS) return STAT_NO_SPACE;
    rec_bytes[at] = 0;
    foreach (live_blocks[i])
      if (live_blocks[i] == at) begin
        live_blocks.delete(i);
        break;
      end
    lb = has_l ? region_beg[li] : 0;
    ll = has_l ? region_len[li] : 0;
    rl = has_r ? region_len[ri] : 0;
    if (has_l && has_r) begin
      if (li > ri) begin
        drop_region(li);
        drop_region(ri);
      end else begin
        drop_region(ri);
        drop_region(li);
      end
      place_region(lb, ll + span + rl);
    end else if (has_l) begin
      drop_region(li);
      place_region(lb, ll + span);
    end else if (has_r) begin
      drop_region(ri);
      place_region(at, span + rl);
    end else place_region(at, span);
    return STAT_OK;
  endfunction

  function automatic result_t predict_outcome(request_t r);
    result_t res;
    res = '{status: STAT_OK, start_block: '0};
    case (r.action)
      ACT_ALLOC:  res = grant_blocks(r.byte_count);
      ACT_FREE:   res.status = release_blocks(r.free_index);
      ACT_REINIT: restore_pool();
      default:    ;
    endcase
    return res;
  endfunction

  // mostly allocs sized near the block and frees of live grants, plus noise
  function automatic request_t random_request();
    request_t    r;
    int unsigned pick, blk;
    blk  = 32'd1 << cur_shift;
    pick = $urandom_range(99);
    r.action     = ACT_ALLOC;
    r.byte_count = BYTES_W'($urandom);
    r.free_index = IDX_W'($urandom);
    if (pick < 40) r.byte_count = BYTES_W'($urandom_range(1, 6 * blk));
    else if (pick < 45) r.byte_count = BYTES_W'($urandom_range(1, 40 * blk));
    else if (pick < 50) ;
    else if (pick < 53) r.byte_count = '0;
    else if (pick < 85) begin
      r.action = ACT_FREE;
      if (live_blocks.size() != 0)
        r.free_index = IDX_W'(live_blocks[$urandom_range(live_blocks.size() - 1)]);
    end else if (pick < 93) r.action = ACT_FREE;
    else if (pick < 96) r.action = ACT_REINIT;
    else r.action = ACT_NONE;
    return r;
  endfunction

  task automatic send_request(request_t r, bit typed, result_t typed_res);
    result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    request <= r;
    push    <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    res = predict_outcome(r);
    awaited_results.push_back(typed ? typed_res : res);
  endtask

  task automatic write_config(logic idx, int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_W-1:0];
    @(posedge clk);
    if (idx == CFG_BLOCK_SHIFT) cur_shift = value & 32'hF;
    else cur_pool = value & 32'h1FF;
  endtask

  // clock and run-length guard
  initial begin
    clk    = 1'b0;
    cycles = 0;
    forever begin
      #5 clk = ~clk;
      if (clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  // result side: random stalls, each popped result checked against the oldest expectation
  initial begin
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result status=%0d block=%0d", result.status,
                     result.start_block);
        end else begin
          result_t want;
          want = awaited_results.pop_front();
          if (result.status !== want.status || result.start_block !== want.start_block) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected status=%0d block=%0d, got status=%0d block=%0d",
                       want.status, want.start_block, result.status, result.start_block);
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // request side
  initial begin
    request_t req;
    result_t  typed_res;
    rst           = 1'b1;
    push          = 1'b0;
    request       = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_BLOCK_SHIFT;
    cfg_data      = '0;
    mismatches    = 0;
    send_idle_pct = 9;
    recv_idle_pct = 83;
    cur_shift     = 6;
    cur_pool      = 256;
    restore_pool();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      req.action         = directed_rows[i].action;
      req.byte_count     = directed_rows[i].bytes;
      req.free_index     = directed_rows[i].idx;
      typed_res.status      = directed_rows[i].status;
      typed_res.start_block = directed_rows[i].blk;
      send_request(req, directed_rows[i].typed, typed_res);
    end

    for (int p = 0; p < PHASES; p++) begin
      // idle profile: sender light first, then receiver light, then no idling
      if (p < 3) begin
        send_idle_pct = 9;
        recv_idle_pct = 83;
      end else if (p < 5) begin
        send_idle_pct = 83;
        recv_idle_pct = 9;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // registers change only with nothing in flight
      push <= 1'b0;
      @(posedge clk);
      while (awaited_results.size() != 0) @(posedge clk);
      write_config(CFG_BLOCK_SHIFT, phase_shift[p]);
      write_config(CFG_POOL_BLOCKS, phase_pool[p]);
      cfg_we <= 1'b0;
      @(posedge clk);
      if (phase_reinit[p]) begin
        req = '{action: ACT_REINIT, byte_count: '0, free_index: '0};
        send_request(req, 1'b0, typed_res);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) send_request(random_request(), 1'b0, typed_res);
    end

    push <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
